FILE: rtl/core/cordic_sin_cos_macros.svh
// ----------------------------------------------------------------------------
// cordic_sin_cos_macros.svh
// Assertion helpers shared by the CORDIC sine/cosine RTL.
// ----------------------------------------------------------------------------
`ifndef CORDIC_SIN_COS_MACROS_SVH
`define CORDIC_SIN_COS_MACROS_SVH

// Same-cycle implication, gated off during reset
`define CORDIC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, gated off during reset
`define CORDIC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/cordic_pkg.sv
// ----------------------------------------------------------------------------
// cordic_pkg
// Types, defaults and elaboration-time constant builders (gain, arctangent
// table) for the CORDIC sine/cosine pipeline.
// ----------------------------------------------------------------------------
package cordic_pkg;

   localparam int unsigned ITERATIONS_DEF    = 32;
   localparam int unsigned FRACTION_BITS_DEF = 30;
   localparam int unsigned IoFrac            = 30;
   localparam int unsigned IoW               = 32;
   localparam int unsigned WordW             = 64;

   typedef logic signed [WordW-1:0] word_type;
   typedef logic signed [IoW-1:0]   io_type;

   // pi/4 with 64 fraction bits, round to nearest
   localparam logic [63:0] QuarterPiQ64 = 64'hC90FDAA22168C235;
   // gain 0.6072529350088812561694, one BCD digit per nibble
   localparam logic [87:0] GainBcd = 88'h6072529350088812561694;
   localparam int unsigned GainDigits = 22;

   // Restoring long division, used at elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] num,
                                          input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(2^-i) with 64 fraction bits by the alternating series
   function automatic logic [63:0] arctan_q64(input int unsigned i);
      logic [63:0] sum;
      logic [63:0] odd;
      logic [63:0] term;
      int unsigned e;
      logic        neg;
      logic        done;
      sum  = '0;
      odd  = 64'd1;
      neg  = 1'b0;
      done = 1'b0;
      e    = 64 - i;
      if (i == 0) begin
         sum  = QuarterPiQ64;
         done = 1'b1;
      end
      for (int k = 0; k < 64; k++) begin
         if (!done) begin
            term = udiv64((64'd1 << e) + (odd >> 1), odd);
            sum  = neg ? sum - term : sum + term;
            neg  = !neg;
            odd  = odd + 64'd2;
            if (e < 2 * i) begin
               done = 1'b1;
            end else begin
               e = e - 2 * i;
            end
         end
      end
      return sum;
   endfunction

   // Decimal gain to 64 fraction bits by repeated doubling, round to nearest
   function automatic logic [63:0] gain_q64();
      logic [87:0] bcd;
      logic [63:0] acc;
      logic [4:0]  v;
      logic        carry;
      bcd = GainBcd;
      acc = '0;
      for (int bit_n = 0; bit_n < 65; bit_n++) begin
         carry = 1'b0;
         for (int j = GainDigits - 1; j >= 0; j--) begin
            v = {bcd[4*(GainDigits-1-j) +: 4], 1'b0} + {4'd0, carry};
            if (v >= 5'd10) begin
               carry = 1'b1;
               v     = v - 5'd10;
            end else begin
               carry = 1'b0;
            end
            bcd[4*(GainDigits-1-j) +: 4] = v[3:0];
         end
         if (bit_n < 64) begin
            acc = {acc[62:0], carry};
         end else if (carry) begin
            acc = acc + 64'd1;
         end
      end
      return acc;
   endfunction

   // Q0.64 constant to internal format, round half up
   function automatic word_type to_internal(input logic [63:0] a,
                                            input int unsigned fb);
      logic [63:0] r;
      r = (a + (64'd1 << (63 - fb))) >> (64 - fb);
      return word_type'(r);
   endfunction

endpackage

FILE: rtl/core/cordic_sin_cos.sv
// ----------------------------------------------------------------------------
// cordic_sin_cos
// Unrolled CORDIC in rotation mode: cosine and sine of a Q2.30 angle, one
// micro-rotation per pipeline stage.
// ----------------------------------------------------------------------------
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   req     | req_valid, req_stall, req_angle        | in
//   rsp     | rsp_valid, rsp_stall, rsp_cosine/sine  | out
//
// Stages: one load stage, one stage per rotation, one rounding/saturation
// stage. One request is taken every cycle while req_stall is low.
// Each stage carries its own valid bit and holds when the stage after it is
// full and stalled, so empty stages still fill while a result waits.
// Synchronous active-high reset clears the valid bits only.
// ----------------------------------------------------------------------------
`include "cordic_sin_cos_macros.svh"

module cordic_sin_cos #(
   parameter int unsigned ITERATIONS    = cordic_pkg::ITERATIONS_DEF,
   parameter int unsigned FRACTION_BITS = cordic_pkg::FRACTION_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cordic_pkg::io_type     req_angle,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cordic_pkg::io_type     rsp_cosine,
   output cordic_pkg::io_type     rsp_sine
);

   localparam int unsigned IoFrac = cordic_pkg::IoFrac;
   localparam int unsigned UpShift = (FRACTION_BITS > IoFrac) ? FRACTION_BITS - IoFrac : 0;
   localparam int unsigned DnShift = (FRACTION_BITS < IoFrac) ? IoFrac - FRACTION_BITS : 0;
   localparam cordic_pkg::word_type RoundAdd =
      (UpShift > 0) ? (cordic_pkg::word_type'(1) <<< (UpShift - 1)) : '0;
   localparam cordic_pkg::word_type OneOut = cordic_pkg::word_type'(1) <<< IoFrac;
   localparam cordic_pkg::word_type GainInit =
      cordic_pkg::to_internal(cordic_pkg::gain_q64(), FRACTION_BITS);

   // per-stage state; w = target - theta - 1, so w < 0 means theta >= target
   logic                 vld_ff  [0:ITERATIONS];
   cordic_pkg::word_type x_ff    [0:ITERATIONS];
   cordic_pkg::word_type y_ff    [0:ITERATIONS];
   cordic_pkg::word_type w_ff    [0:ITERATIONS];
   logic                 stg_rdy [0:ITERATIONS];

   logic                 rsp_vld_ff;
   cordic_pkg::io_type   cos_ff;
   cordic_pkg::io_type   sin_ff;
   logic                 out_rdy;
   cordic_pkg::word_type tgt_ext;
   cordic_pkg::word_type cos_in;
   cordic_pkg::word_type sin_in;

   // ready chain: a stage takes new data when empty or when it drains
   assign out_rdy = !rsp_vld_ff || !rsp_stall;
   assign stg_rdy[ITERATIONS] = !vld_ff[ITERATIONS] || out_rdy;
   for (genvar k = 0; k < ITERATIONS; k++) begin : g_rdy
      assign stg_rdy[k] = !vld_ff[k] || stg_rdy[k+1];
   end
   assign req_stall = !stg_rdy[0];

   // load stage: angle into internal format
   assign tgt_ext = ((cordic_pkg::word_type'(req_angle)) <<< UpShift) >>> DnShift;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (stg_rdy[0]) begin
         vld_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[0] && req_valid) begin
         x_ff[0] <= GainInit;
         y_ff[0] <= '0;
         w_ff[0] <= tgt_ext - cordic_pkg::word_type'(1);
      end
   end

   // rotation stages, iteration k-1 in stage k
   for (genvar k = 1; k <= ITERATIONS; k++) begin : g_rot
      localparam int unsigned Sh = k - 1;
      localparam cordic_pkg::word_type Arc =
         cordic_pkg::to_internal(cordic_pkg::arctan_q64(k - 1), FRACTION_BITS);
      cordic_pkg::word_type xs;
      cordic_pkg::word_type ys;
      cordic_pkg::word_type x_in;
      cordic_pkg::word_type y_in;
      cordic_pkg::word_type w_in;
      logic                 cw;

      // clockwise when theta has reached the target
      always_comb begin
         xs = x_ff[k-1] >>> Sh;
         ys = y_ff[k-1] >>> Sh;
         cw = w_ff[k-1][cordic_pkg::WordW-1];
         if (cw) begin
            x_in = x_ff[k-1] + ys;
            y_in = y_ff[k-1] - xs;
            w_in = w_ff[k-1] + Arc;
         end else begin
            x_in = x_ff[k-1] - ys;
            y_in = y_ff[k-1] + xs;
            w_in = w_ff[k-1] - Arc;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (stg_rdy[k]) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (stg_rdy[k] && vld_ff[k-1]) begin
            x_ff[k] <= x_in;
            y_ff[k] <= y_in;
            w_ff[k] <= w_in;
         end
      end
   end

   // output stage: round to Q2.30, saturate to [-1, +1]
   function automatic cordic_pkg::io_type to_io(input cordic_pkg::word_type v);
      cordic_pkg::word_type r;
      r = ((v + RoundAdd) >>> UpShift) <<< DnShift;
      if (r > OneOut) begin
         r = OneOut;
      end else if (r < -OneOut) begin
         r = -OneOut;
      end
      return r[cordic_pkg::IoW-1:0];
   endfunction

   assign cos_in = x_ff[ITERATIONS];
   assign sin_in = y_ff[ITERATIONS];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_vld_ff <= vld_ff[ITERATIONS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy && vld_ff[ITERATIONS]) begin
         cos_ff <= to_io(cos_in);
         sin_ff <= to_io(sin_in);
      end
   end

   assign rsp_valid  = rsp_vld_ff;
   assign rsp_cosine = cos_ff;
   assign rsp_sine   = sin_ff;

   // checks
   `CORDIC_ASSERT_NOW(a_cos_range, clock, reset, rsp_valid,
      (rsp_cosine <= 32'sh4000_0000) && (rsp_cosine >= -32'sh4000_0000),
      "cosine outside [-1, +1]")
   `CORDIC_ASSERT_NOW(a_sin_range, clock, reset, rsp_valid,
      (rsp_sine <= 32'sh4000_0000) && (rsp_sine >= -32'sh4000_0000),
      "sine outside [-1, +1]")
   `CORDIC_ASSERT_NEXT(a_load, clock, reset, req_valid && !req_stall, vld_ff[0],
      "accepted request missing from load stage")
   `CORDIC_ASSERT_NOW(a_stall_full, clock, reset, req_stall,
      vld_ff[0] && rsp_valid && rsp_stall,
      "input stalled while pipeline has room")

endmodule
